// ===== rtl/servo_sync_write_frame_encoder_macros.svh =====
// Assertion macros for the checker file of the frame encoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SERVO_SYNC_WRITE_FRAME_ENCODER_MACROS_SVH
`define SERVO_SYNC_WRITE_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, off during reset
`define SSW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssw: same-cycle check failed");

// next-cycle implication, off during reset
`define SSW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssw: next-cycle check failed");

`endif

// ===== rtl/ssw_pkg.sv =====
// Types, constants and defaults for the servo sync-write frame encoder.
// No dependencies; every RTL module but the checker imports it.
package ssw_pkg;

  localparam int MAX_SERVOS_DEF  = 31;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int COUNT_W         = 5;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [7:0]  BCAST_ID   = 8'hFE;
  localparam logic [15:0] SIGN_BIT   = 16'h8000;
  localparam logic [7:0]  REC_LEN    = 8'd7;
  localparam logic [7:0]  LEN_OFFSET = 8'd4;

  localparam logic       BYTE_ORDER_RST = 1'b0;
  localparam logic [7:0] SYNC_CODE_RST  = 8'd131;
  localparam logic [7:0] START_REG_RST  = 8'd41;

  localparam logic [1:0] CFG_IDX_BYTE_ORDER = 2'd0;
  localparam logic [1:0] CFG_IDX_SYNC_CODE  = 2'd1;
  localparam logic [1:0] CFG_IDX_START_REG  = 2'd2;

  // byte positions inside the bytes one record can emit
  typedef enum logic [3:0] {
    SLOT_SYNC0    = 4'd0,
    SLOT_SYNC1    = 4'd1,
    SLOT_BCAST    = 4'd2,
    SLOT_LEN      = 4'd3,
    SLOT_INSTR    = 4'd4,
    SLOT_START    = 4'd5,
    SLOT_RLEN     = 4'd6,
    SLOT_SID      = 4'd7,
    SLOT_ACCEL    = 4'd8,
    SLOT_POS_A    = 4'd9,
    SLOT_POS_B    = 4'd10,
    SLOT_TRQ_A    = 4'd11,
    SLOT_TRQ_B    = 4'd12,
    SLOT_SPD_A    = 4'd13,
    SLOT_SPD_B    = 4'd14,
    SLOT_CSUM     = 4'd15
  } slot_t;

  typedef struct packed {
    logic        hdr;
    logic        last;
    logic [7:0]  len;
    logic [7:0]  id;
    logic [7:0]  accel;
    logic [15:0] pword;
    logic [15:0] torque;
    logic [15:0] speed;
  } rec_t;

  typedef struct packed {
    logic       byte_order;
    logic [7:0] sync_code;
    logic [7:0] start_reg;
  } cfg_t;

endpackage

// ===== rtl/ssw_queue.sv =====
// Short record queue between the front and back of the frame encoder.
// Depends on ssw_pkg for the record type.
module ssw_queue #(
  parameter int DEPTH = ssw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ssw_pkg::rec_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ssw_pkg::rec_t pop_data
);
  import ssw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ssw_front.sv =====
// Front of the frame encoder: takes servo records, checks the count,
// tracks the open frame and queues records that emit bytes. Uses ssw_pkg.
module ssw_front #(
  parameter int MAX_SERVOS = ssw_pkg::MAX_SERVOS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  servo_id,
  input  logic signed [15:0]          position,
  input  logic [15:0]                 speed,
  input  logic [7:0]                  accel,
  input  logic [15:0]                 torque,
  input  logic                        first_record,
  input  logic                        last_record,
  input  logic [ssw_pkg::COUNT_W-1:0] servo_count,
  output logic                        push_valid,
  input  logic                        push_ready,
  output ssw_pkg::rec_t               push_data
);
  import ssw_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SERVOS);

  logic        in_frame_r, in_frame_nxt;
  logic        accept, refused, keep;
  logic [15:0] pos_u, mag;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign refused  = (servo_count == '0) || (servo_count > COUNT_MAX);
  // a first record opens a frame unless refused; others need an open frame
  assign keep     = first_record ? !refused : in_frame_r;

  assign pos_u = position;
  assign mag   = ~pos_u + 16'd1;

  always_comb begin
    push_valid       = accept && keep;
    push_data.hdr    = first_record;
    push_data.last   = last_record;
    push_data.len    = {servo_count, 3'b000} + LEN_OFFSET;
    push_data.id     = servo_id;
    push_data.accel  = accel;
    push_data.pword  = pos_u[15] ? (mag | SIGN_BIT) : pos_u;
    push_data.torque = torque;
    push_data.speed  = speed;
    in_frame_nxt     = accept ? (keep && !last_record) : in_frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ===== rtl/ssw_back.sv =====
// Back of the frame encoder: walks the bytes of each queued record,
// keeps the checksum and drives the output register. Uses ssw_pkg.
module ssw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ssw_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  ssw_pkg::rec_t pop_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_frame_end,
  output logic          out_run_end
);
  import ssw_pkg::*;

  logic       busy_r, busy_nxt;
  slot_t      slot_r, slot_nxt;
  rec_t       rec_r, rec_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       fend_r, fend_nxt;
  logic       rend_r, rend_nxt;

  logic       space, adv, at_end, take;
  slot_t      end_slot;
  logic [7:0] cur;

  assign space     = !ovalid_r || out_ready;
  assign adv       = busy_r && space;
  assign end_slot  = rec_r.last ? SLOT_CSUM : SLOT_SPD_B;
  assign at_end    = (slot_r == end_slot);
  assign pop_ready = !busy_r || (adv && at_end);
  assign take      = pop_valid && pop_ready;

  assign out_valid     = ovalid_r;
  assign out_byte      = obyte_r;
  assign out_frame_end = fend_r;
  assign out_run_end   = rend_r;

  always_comb begin
    unique case (slot_r)
      SLOT_SYNC0: cur = SYNC_BYTE;
      SLOT_SYNC1: cur = SYNC_BYTE;
      SLOT_BCAST: cur = BCAST_ID;
      SLOT_LEN:   cur = rec_r.len;
      SLOT_INSTR: cur = cfg.sync_code;
      SLOT_START: cur = cfg.start_reg;
      SLOT_RLEN:  cur = REC_LEN;
      SLOT_SID:   cur = rec_r.id;
      SLOT_ACCEL: cur = rec_r.accel;
      SLOT_POS_A: cur = cfg.byte_order ? rec_r.pword[15:8] : rec_r.pword[7:0];
      SLOT_POS_B: cur = cfg.byte_order ? rec_r.pword[7:0] : rec_r.pword[15:8];
      SLOT_TRQ_A: cur = cfg.byte_order ? rec_r.torque[15:8] : rec_r.torque[7:0];
      SLOT_TRQ_B: cur = cfg.byte_order ? rec_r.torque[7:0] : rec_r.torque[15:8];
      SLOT_SPD_A: cur = cfg.byte_order ? rec_r.speed[15:8] : rec_r.speed[7:0];
      SLOT_SPD_B: cur = cfg.byte_order ? rec_r.speed[7:0] : rec_r.speed[15:8];
      SLOT_CSUM:  cur = ~sum_r;
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    slot_nxt   = slot_r;
    rec_nxt    = rec_r;
    sum_nxt    = sum_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    fend_nxt   = fend_r;
    rend_nxt   = rend_r;

    if (adv) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur;
      fend_nxt   = (slot_r == SLOT_CSUM);
      rend_nxt   = at_end;
      // the sync bytes and the checksum stay out of the sum
      priority case (slot_r)
        SLOT_SYNC0, SLOT_SYNC1, SLOT_CSUM: sum_nxt = sum_r;
        SLOT_BCAST:                        sum_nxt = cur;
        default:                           sum_nxt = sum_r + cur;
      endcase
      if (!at_end) begin
        slot_nxt = slot_t'(4'(slot_r) + 4'd1);
      end
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end

    if (take) begin
      busy_nxt = 1'b1;
      rec_nxt  = pop_data;
      slot_nxt = pop_data.hdr ? SLOT_SYNC0 : SLOT_SID;
    end else if (adv && at_end) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      slot_r   <= SLOT_SYNC0;
      sum_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      slot_r   <= slot_nxt;
      sum_r    <= sum_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    obyte_r <= obyte_nxt;
    fend_r  <= fend_nxt;
    rend_r  <= rend_nxt;
  end

endmodule

// ===== rtl/servo_sync_write_frame_encoder.sv =====
// Sync-write frame encoder: one servo record in, 8 to 16 bus bytes out.
// When the back is idle, a record passes the queue and the back-end record
// register before its first byte is registered. Throughput: one byte per cycle
// unless out_tready stalls; the back end loads the next record on its last byte.
// Reset (rst_n low, synchronous) closes any frame, empties the queue and
// restores byte_order 0, instruction code 131 and start register 41.
module servo_sync_write_frame_encoder #(
  parameter int MAX_SERVOS  = ssw_pkg::MAX_SERVOS_DEF,
  parameter int QUEUE_DEPTH = ssw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: servo_id[7:0], position[15:0], speed[15:0],
  // accel[7:0], torque[15:0], servo_count[4:0], zero pad[2:0]
  input  logic [71:0] in_tdata,
  // in_tuser: first_record
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, from bit 0: out_byte[7:0]
  output logic [7:0]  out_tdata,
  // out_tuser: run_end
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);
  import ssw_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic push_valid, push_ready, pop_valid, pop_ready;
  rec_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_IDX_BYTE_ORDER: cfg_nxt.byte_order = cfg_data[0];
        CFG_IDX_SYNC_CODE:  cfg_nxt.sync_code  = cfg_data;
        CFG_IDX_START_REG:  cfg_nxt.start_reg  = cfg_data;
        default:            cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_order <= BYTE_ORDER_RST;
      cfg_r.sync_code  <= SYNC_CODE_RST;
      cfg_r.start_reg  <= START_REG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssw_front #(
    .MAX_SERVOS(MAX_SERVOS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .servo_id    (in_tdata[7:0]),
    .position    (in_tdata[23:8]),
    .speed       (in_tdata[39:24]),
    .accel       (in_tdata[47:40]),
    .torque      (in_tdata[63:48]),
    .first_record(in_tuser),
    .last_record (in_tlast),
    .servo_count (in_tdata[68:64]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  ssw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  ssw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_frame_end(out_tlast),
    .out_run_end  (out_tuser)
  );

endmodule

// ===== rtl/ssw_checker.sv =====
// Port-level checks for the sync-write frame encoder, bound to the top.
// Depends on servo_sync_write_frame_encoder_macros.svh.
`include "servo_sync_write_frame_encoder_macros.svh"

module ssw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  // the checksum beat always closes its run
  `SSW_ASSERT_IMP(a_csum_ends_run, out_tvalid && out_tlast, out_tuser)

  // bytes of one run leave without gaps once the first is taken
  `SSW_ASSERT_NXT(a_run_no_gap, out_tvalid && out_tready && !out_tuser, out_tvalid)

  // hold a stalled beat
  `SSW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

endmodule

bind servo_sync_write_frame_encoder ssw_checker u_ssw_checker (.*);
